// ===== hdl/tlc_pkg.sv =====
// Shared types, constants and a digit decode function for the traffic light countdown block.
`timescale 1ns / 1ps

package tlc_pkg;

  // Width of the scan slot tick counter.
  localparam int SLOT_CNT_W = 16;
  // Width of the slot length register.
  localparam int SLOT_TICKS_W = 16;
  // Width used to compare the incremented counter against the slot length.
  localparam int SLOT_CMP_W = (SLOT_CNT_W + 1 > SLOT_TICKS_W) ? SLOT_CNT_W + 1 : SLOT_TICKS_W;

  // Width of phase durations, elapsed seconds and displayed values.
  localparam int SEC_W = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [SEC_W-1:0] DISPLAY_MAX = SEC_W'(99);
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [SEC_W-1:0] RED_RESET = SEC_W'(5);
  localparam logic [SEC_W-1:0] YELLOW_RESET = SEC_W'(2);
  localparam logic [SEC_W-1:0] GREEN_RESET = SEC_W'(3);
  localparam logic [SLOT_TICKS_W-1:0] SLOT_TICKS_RESET = SLOT_TICKS_W'(250);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_YELLOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_TICKS = 2'd3;

  // Lamp phase; the encoding is also the lamp code on the outputs.
  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_YELLOW = 2'd1,
    PH_GREEN  = 2'd2
  } phase_t;

  // Phase durations handed to each lane.
  typedef struct packed {
    logic [SEC_W-1:0] red_s;
    logic [SEC_W-1:0] yellow_s;
    logic [SEC_W-1:0] green_s;
  } durations_t;

  // Seven-segment pattern for a decimal digit, segments a to g in bits 0 to 6, active high.
  function automatic logic [6:0] seg_font(input logic [3:0] digit);
    logic [6:0] pat;
    unique case (digit)
      4'd0: pat = 7'h3f;
      4'd1: pat = 7'h06;
      4'd2: pat = 7'h5b;
      4'd3: pat = 7'h4f;
      4'd4: pat = 7'h66;
      4'd5: pat = 7'h6d;
      4'd6: pat = 7'h7d;
      4'd7: pat = 7'h07;
      4'd8: pat = 7'h7f;
      4'd9: pat = 7'h67;
      default: pat = 7'h3f;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/tlc_lane.sv =====
// One lane's phase sequencer with its elapsed seconds and remaining time view.
`timescale 1ns / 1ps

module tlc_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlc_pkg::phase_t            init_phase,
  input  tlc_pkg::durations_t        dur,
  input  logic                       second_pulse,
  output tlc_pkg::phase_t            phase_nxt,
  output logic [tlc_pkg::SEC_W-1:0]  remain_nxt
);
  import tlc_pkg::*;

  phase_t           phase_r;
  logic [SEC_W-1:0] elapsed_r;
  logic [SEC_W-1:0] elapsed_nxt;
  logic [SEC_W:0]   elapsed_inc;
  logic [SEC_W-1:0] cur_len;
  logic [SEC_W-1:0] nxt_len;

  // Duration of a phase; zero counts as one second.
  function automatic logic [SEC_W-1:0] phase_len(input phase_t ph, input durations_t d);
    logic [SEC_W-1:0] len;
    unique case (ph)
      PH_GREEN:  len = d.green_s;
      PH_YELLOW: len = d.yellow_s;
      default:   len = d.red_s;
    endcase
    if (len == '0) begin
      len = SEC_W'(1);
    end
    return len;
  endfunction

  // Advance elapsed time once per second and step the phase at its end.
  always_comb begin
    cur_len     = phase_len(phase_r, dur);
    elapsed_inc = {1'b0, elapsed_r} + (SEC_W + 1)'(1);
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    if (second_pulse) begin
      if (elapsed_inc >= {1'b0, cur_len}) begin
        elapsed_nxt = '0;
        unique case (phase_r)
          PH_GREEN:  phase_nxt = PH_YELLOW;
          PH_YELLOW: phase_nxt = PH_RED;
          default:   phase_nxt = PH_GREEN;
        endcase
      end else begin
        elapsed_nxt = elapsed_inc[SEC_W-1:0];
      end
    end
  end

  // Remaining seconds after the update, clamped at zero and at the display maximum.
  always_comb begin
    nxt_len = phase_len(phase_nxt, dur);
    if (elapsed_nxt >= nxt_len) begin
      remain_nxt = '0;
    end else begin
      remain_nxt = nxt_len - elapsed_nxt;
    end
    if (remain_nxt > DISPLAY_MAX) begin
      remain_nxt = DISPLAY_MAX;
    end
  end

  // Lane state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= init_phase;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// ===== hdl/two_lane_traffic_light_countdown_top.sv =====
// Top level of the two-lane traffic light controller with seven-segment countdown.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the in_ channel carries one time-base tick flag (in_tick).
// Every slot_ticks ticks the display scan steps to the next of four digits,
// and each wrap of the scan is one second for both lanes. Lane 1 starts red,
// lane 2 green; each runs red, green, yellow for its configured seconds.
// Every input transfer yields exactly one output transfer with both lamps,
// the enabled digit and its active-low segments, showing the state after the
// tick. Digits 0 and 1 show lane 1's remaining seconds, digits 2 and 3 lane 2's.
// One item is taken in every cycle while the receiver does not stall; the
// single output register sets that rate.
// When the receiver stalls, the output register holds its result and
// in_ready drops until that result is taken.
// The cfg_ channel writes a register by index (red, yellow, green seconds,
// slot ticks) and is always ready; write it only while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults, both lanes'
// start phases, the scan position and empties the output register.

module two_lane_traffic_light_countdown_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_lane1_light,
  output logic [1:0]                        out_lane2_light,
  output logic [1:0]                        out_digit_select,
  output logic [6:0]                        out_segments,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tlc_pkg::*;

  durations_t              dur_r;
  logic [SLOT_TICKS_W-1:0] slot_ticks_r;

  logic [SLOT_CNT_W-1:0]   slot_cnt_r;
  logic [SLOT_CNT_W-1:0]   slot_cnt_nxt;
  logic [1:0]              slot_r;
  logic [1:0]              slot_nxt;
  logic [SLOT_CMP_W-1:0]   cnt_inc;
  logic [SLOT_CMP_W-1:0]   slot_limit;

  logic                    in_xfer;
  logic                    tick_go;
  logic                    second_pulse;

  phase_t                  lane1_phase_nxt;
  phase_t                  lane2_phase_nxt;
  logic [SEC_W-1:0]        lane1_remain;
  logic [SEC_W-1:0]        lane2_remain;

  logic [SEC_W-1:0]        shown;
  logic [14:0]             tens_prod;
  logic [3:0]              tens;
  logic [3:0]              units;
  logic [3:0]              digit;

  logic                    out_valid_r;
  logic [1:0]              lane1_light_r;
  logic [1:0]              lane2_light_r;
  logic [1:0]              digit_sel_r;
  logic [6:0]              segments_r;

  // Handshake: a new item enters whenever the output register is free or being emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign tick_go   = in_xfer && in_tick;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r.red_s    <= RED_RESET;
      dur_r.yellow_s <= YELLOW_RESET;
      dur_r.green_s  <= GREEN_RESET;
      slot_ticks_r   <= SLOT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED:        dur_r.red_s    <= cfg_data[SEC_W-1:0];
        REG_YELLOW:     dur_r.yellow_s <= cfg_data[SEC_W-1:0];
        REG_GREEN:      dur_r.green_s  <= cfg_data[SEC_W-1:0];
        REG_SLOT_TICKS: slot_ticks_r   <= cfg_data[SLOT_TICKS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Scan slot timing; a slot length of zero ends a slot on every tick.
  always_comb begin
    cnt_inc      = SLOT_CMP_W'(slot_cnt_r) + SLOT_CMP_W'(1);
    slot_limit   = (slot_ticks_r == '0) ? SLOT_CMP_W'(1) : SLOT_CMP_W'(slot_ticks_r);
    slot_cnt_nxt = slot_cnt_r;
    slot_nxt     = slot_r;
    second_pulse = 1'b0;
    if (tick_go) begin
      if (cnt_inc >= slot_limit) begin
        slot_cnt_nxt = '0;
        slot_nxt     = slot_r + 2'd1;
        second_pulse = (slot_r == LAST_SLOT);
      end else begin
        slot_cnt_nxt = cnt_inc[SLOT_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      slot_r     <= '0;
    end else begin
      slot_cnt_r <= slot_cnt_nxt;
      slot_r     <= slot_nxt;
    end
  end

  // The two lane sequencers.
  tlc_lane u_lane1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .init_phase   (PH_RED),
    .dur          (dur_r),
    .second_pulse (second_pulse),
    .phase_nxt    (lane1_phase_nxt),
    .remain_nxt   (lane1_remain)
  );

  tlc_lane u_lane2 (
    .clk          (clk),
    .rst_n        (rst_n),
    .init_phase   (PH_GREEN),
    .dur          (dur_r),
    .second_pulse (second_pulse),
    .phase_nxt    (lane2_phase_nxt),
    .remain_nxt   (lane2_remain)
  );

  // Digit decode: tens by multiplying with 205/2048, exact for values up to 99.
  always_comb begin
    shown     = slot_nxt[1] ? lane2_remain : lane1_remain;
    tens_prod = 15'(shown) * 15'd205;
    tens      = tens_prod[14:11];
    units     = 4'(shown - SEC_W'(tens) * SEC_W'(10));
    digit     = slot_nxt[0] ? units : tens;
  end

  // Output register with its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lane1_light_r <= lane1_phase_nxt;
      lane2_light_r <= lane2_phase_nxt;
      digit_sel_r   <= slot_nxt;
      segments_r    <= ~seg_font(digit);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lane1_light  = lane1_light_r;
  assign out_lane2_light  = lane2_light_r;
  assign out_digit_select = digit_sel_r;
  assign out_segments     = segments_r;

endmodule
